>>> rtl/ghv_pkg.sv
// shared types and constants for the gzip member header checker
// no dependencies; used by every module under rtl

package ghv_pkg;

    parameter int unsigned FIXED_HEADER_LEN = 10;

    localparam logic [7:0] MAGIC0         = 8'h1F;
    localparam logic [7:0] MAGIC1         = 8'h8B;
    localparam logic [7:0] METHOD_DEFLATE = 8'h08;
    localparam logic [7:0] RESERVED_MASK  = 8'hE0;

    localparam logic [4:0] FLG_CRC     = 5'h02;
    localparam logic [4:0] FLG_EXTRA   = 5'h04;
    localparam logic [4:0] FLG_NAME    = 5'h08;
    localparam logic [4:0] FLG_COMMENT = 5'h10;

    localparam logic [15:0] POS_MAGIC0 = 16'd0;
    localparam logic [15:0] POS_MAGIC1 = 16'd1;
    localparam logic [15:0] POS_METHOD = 16'd2;
    localparam logic [15:0] POS_FLAGS  = 16'd3;
    localparam logic [15:0] POS_LAST_FIXED = 16'(FIXED_HEADER_LEN - 1);
    localparam logic [15:0] POS_MAX    = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_FIXED   = 3'd0,
        PH_XLO     = 3'd1,
        PH_XHI     = 3'd2,
        PH_XSKIP   = 3'd3,
        PH_NAME    = 3'd4,
        PH_COMMENT = 3'd5,
        PH_CRC     = 3'd6,
        PH_NONE    = 3'd7
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        is_gzip;
        logic [15:0] header_bytes;
    } t_out_item;

    // verdict handed from the parser to the output queue
    typedef struct packed {
        logic      push;
        t_out_item item;
    } t_vq_wr;

endpackage

>>> rtl/gzip_header_validator.sv
// top level of the gzip member header checker
// depends on ghv_pkg, ghv_front and ghv_queue
//
// input channel: one buffer byte per transaction with a flag on its final
// byte; a transaction completes when i_in_valid is high and o_in_stall low.
// output channel: one verdict per buffer (is_gzip, header_bytes), taken when
// o_out_valid is high and i_out_stall low.
// i_cfg_wr_en writes full_check from i_cfg_wr_data: 0 accepts after the
// fixed ten-byte header, 1 also walks extra, name, comment and header crc.
// one byte per cycle while o_in_stall is low; the front end parses each byte
// combinationally, and a verdict is registered in the output register, or in
// the skid entry while the receiver holds the output.
// bytes after a verdict are taken and dropped up to the final byte.
// when the receiver stalls, the held verdict stays in the output register
// and one more verdict fits in a skid entry; o_in_stall rises only while
// that entry is occupied, so bytes that decide nothing keep flowing until then.
// reset (synchronous, active low) clears full_check, the parse state and
// both output entries; there is no clearing pass.

module gzip_header_validator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ghv_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ghv_pkg::t_out_item o_out_data
);

    ghv_pkg::t_vq_wr s_wr;
    logic            s_full;
    logic            s_accept;

    assign o_in_stall = s_full;
    assign s_accept   = i_in_valid && !s_full;

    ghv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (s_accept),
        .i_item        (i_in_data),
        .o_wr          (s_wr)
    );

    ghv_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (s_wr),
        .o_full      (s_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/ghv_front.sv
// front end: accepts bytes, holds the mode register, walks the header
// depends on ghv_pkg; feeds verdicts to ghv_queue

module ghv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_accept,
    input  ghv_pkg::t_in_item i_item,
    output ghv_pkg::t_vq_wr   o_wr
);

    logic              r_full_check;
    ghv_pkg::t_phase   r_phase, n_phase;
    logic [15:0]       r_count, n_count;
    logic [4:0]        r_flags, n_flags;
    logic [15:0]       r_pos, n_pos;
    logic              r_given, n_given;

    logic              s_reject;
    logic              s_accept_hit;
    logic              s_done;
    ghv_pkg::t_phase   s_next;
    logic [15:0]       s_pos_inc;
    logic [15:0]       s_count_dec;
    logic [7:0]        s_b;
    logic              s_last;

    // first optional field after ph that the flags still ask for
    function automatic ghv_pkg::t_phase next_field(ghv_pkg::t_phase ph, logic [4:0] flg);
        ghv_pkg::t_phase res;
        res = ghv_pkg::PH_NONE;
        if (ph < ghv_pkg::PH_XLO && (flg & ghv_pkg::FLG_EXTRA) != 5'd0) begin
            res = ghv_pkg::PH_XLO;
        end else if (ph < ghv_pkg::PH_NAME && (flg & ghv_pkg::FLG_NAME) != 5'd0) begin
            res = ghv_pkg::PH_NAME;
        end else if (ph < ghv_pkg::PH_COMMENT && (flg & ghv_pkg::FLG_COMMENT) != 5'd0) begin
            res = ghv_pkg::PH_COMMENT;
        end else if (ph < ghv_pkg::PH_CRC && (flg & ghv_pkg::FLG_CRC) != 5'd0) begin
            res = ghv_pkg::PH_CRC;
        end
        return res;
    endfunction

    assign s_b         = i_item.data_byte;
    assign s_last      = i_item.last_byte;
    assign s_pos_inc   = r_pos + 16'(r_pos != ghv_pkg::POS_MAX);
    assign s_count_dec = r_count - 16'(r_count != 16'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_check <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_full_check <= i_cfg_wr_data;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_count      = r_count;
        n_flags      = r_flags;
        n_pos        = r_pos;
        n_given      = r_given;
        s_reject     = 1'b0;
        s_accept_hit = 1'b0;
        s_done       = 1'b0;
        s_next       = ghv_pkg::PH_NONE;

        if (i_accept && !r_given) begin
            n_pos = s_pos_inc;
            unique case (r_phase)
                ghv_pkg::PH_FIXED: begin
                    if ((r_pos == ghv_pkg::POS_MAGIC0 && s_b != ghv_pkg::MAGIC0) ||
                        (r_pos == ghv_pkg::POS_MAGIC1 && s_b != ghv_pkg::MAGIC1) ||
                        (r_pos == ghv_pkg::POS_METHOD && s_b != ghv_pkg::METHOD_DEFLATE) ||
                        (r_pos == ghv_pkg::POS_FLAGS &&
                         (s_b & ghv_pkg::RESERVED_MASK) != 8'd0)) begin
                        s_reject = 1'b1;
                    end else begin
                        if (r_pos == ghv_pkg::POS_FLAGS) begin
                            n_flags = s_b[4:0];
                        end
                        if (r_pos >= ghv_pkg::POS_LAST_FIXED) begin
                            if (!r_full_check) begin
                                s_accept_hit = 1'b1;
                            end else begin
                                s_done = 1'b1;
                            end
                        end else if (s_last) begin
                            s_reject = 1'b1;
                        end
                    end
                end
                ghv_pkg::PH_XLO: begin
                    n_count = {8'd0, s_b};
                    if (s_last) begin
                        s_reject = 1'b1;
                    end else begin
                        n_phase = ghv_pkg::PH_XHI;
                    end
                end
                ghv_pkg::PH_XHI: begin
                    n_count = {s_b, r_count[7:0]};
                    if (n_count == 16'd0) begin
                        s_done = 1'b1;
                    end else if (s_last) begin
                        s_reject = 1'b1;
                    end else begin
                        n_phase = ghv_pkg::PH_XSKIP;
                    end
                end
                ghv_pkg::PH_XSKIP: begin
                    n_count = s_count_dec;
                    if (s_count_dec == 16'd0) begin
                        s_done = 1'b1;
                    end else if (s_last) begin
                        s_reject = 1'b1;
                    end
                end
                ghv_pkg::PH_NAME, ghv_pkg::PH_COMMENT: begin
                    if (s_b == 8'd0 || s_last) begin
                        s_done = 1'b1;
                    end
                end
                ghv_pkg::PH_CRC: begin
                    if (r_count == 16'd0) begin
                        if (s_last) begin
                            s_reject = 1'b1;
                        end else begin
                            n_count = 16'd1;
                        end
                    end else begin
                        s_done = 1'b1;
                    end
                end
                ghv_pkg::PH_NONE: begin
                    s_reject = 1'b1;
                end
                default: begin
                    s_reject = 1'b1;
                end
            endcase

            if (s_done) begin
                // flags may have been captured on this very byte
                s_next = next_field(r_phase, n_flags);
                if (s_next == ghv_pkg::PH_NONE) begin
                    s_accept_hit = 1'b1;
                end else if (s_last) begin
                    s_reject = 1'b1;
                end else begin
                    n_phase = s_next;
                    n_count = 16'd0;
                end
            end

            if (s_accept_hit || s_reject) begin
                n_given = !s_last;
            end
        end

        // restart on the final byte once the verdict is out
        if (i_accept && s_last && (r_given || s_accept_hit || s_reject)) begin
            n_phase = ghv_pkg::PH_FIXED;
            n_count = 16'd0;
            n_flags = 5'd0;
            n_pos   = 16'd0;
            n_given = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ghv_pkg::PH_FIXED;
            r_count <= 16'd0;
            r_flags <= 5'd0;
            r_pos   <= 16'd0;
            r_given <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_flags <= n_flags;
            r_pos   <= n_pos;
            r_given <= n_given;
        end
    end

    always_comb begin
        o_wr.push              = s_accept_hit || s_reject;
        o_wr.item.is_gzip      = s_accept_hit;
        o_wr.item.header_bytes = s_pos_inc;
    end

endmodule

>>> rtl/ghv_queue.sv
// back end: output register plus one skid entry for verdicts
// depends on ghv_pkg; fed by ghv_front

module ghv_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ghv_pkg::t_vq_wr    i_wr,
    output logic               o_full,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ghv_pkg::t_out_item o_out_data
);

    logic               r_out_vld, n_out_vld;
    ghv_pkg::t_out_item r_out, n_out;
    logic               r_skid_vld, n_skid_vld;
    ghv_pkg::t_out_item r_skid, n_skid;
    logic               s_free;

    assign s_free = !r_out_vld || !i_out_stall;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_skid_vld = r_skid_vld;
        n_skid     = r_skid;
        if (s_free) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_out_vld  = 1'b1;
                n_skid_vld = i_wr.push;
                n_skid     = i_wr.item;
            end else begin
                n_out_vld  = i_wr.push;
                n_out      = i_wr.item;
            end
        end else if (i_wr.push) begin
            // output held, park the new verdict
            n_skid_vld = 1'b1;
            n_skid     = i_wr.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full      = r_skid_vld;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

>>> rtl/ghv_checker.sv
// port-level checks for gzip_header_validator, attached by bind
// depends on ghv_pkg

module ghv_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_wr_en,
    input logic               i_cfg_wr_data,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input ghv_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ghv_pkg::t_out_item o_out_data
);

    // a stalled verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled verdict changed");

    // both sides come out of reset empty and open
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset left state behind");

    // input stalls only while a verdict is waiting at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    // a verdict always counts its deciding byte
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.header_bytes != 16'd0)
        else $error("verdict with zero byte count");

    // acceptance needs at least the fixed header
    a_accept_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_gzip |->
            o_out_data.header_bytes >= 16'(ghv_pkg::FIXED_HEADER_LEN))
        else $error("accepted before fixed header ended");

endmodule

bind gzip_header_validator ghv_checker u_ghv_checker (.*);

>>> test/gzip_header_validator_tb.sv
// self-checking testbench for gzip_header_validator: byte streams in, verdicts out
// depends on ghv_pkg for the payload structs, header constants and phase codes
// a built-in header parser predicts each verdict; random idling on both channels

module gzip_header_validator_tb;

    localparam int unsigned IDLE_LIMIT = 2000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic               i_cfg_wr_data = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    ghv_pkg::t_in_item  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    ghv_pkg::t_out_item o_out_data;

    // predicted parser state
    bit                 gz_full;
    ghv_pkg::t_phase    gz_phase;
    logic [15:0]        gz_count;
    logic [4:0]         gz_flags;
    logic [15:0]        gz_pos;
    bit                 gz_decided;

    ghv_pkg::t_out_item verdict_q[$];
    ghv_pkg::t_out_item want;
    logic [7:0]         stim_bytes[$];

    int unsigned error_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned verdicts_taken = 0;
    int unsigned verdicts_drawn = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned in_wait_max = 14;
    int unsigned out_wait_max = 14;

    gzip_header_validator DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void gz_restart();
        gz_phase   = ghv_pkg::PH_FIXED;
        gz_count   = '0;
        gz_flags   = '0;
        gz_pos     = '0;
        gz_decided = 1'b0;
    endfunction

    // first optional field after the given one that the flags call for
    function automatic ghv_pkg::t_phase next_optional_field(input ghv_pkg::t_phase cur);
        if (cur < ghv_pkg::PH_XLO && (gz_flags & ghv_pkg::FLG_EXTRA) != 0)
            return ghv_pkg::PH_XLO;
        if (cur < ghv_pkg::PH_NAME && (gz_flags & ghv_pkg::FLG_NAME) != 0)
            return ghv_pkg::PH_NAME;
        if (cur < ghv_pkg::PH_COMMENT && (gz_flags & ghv_pkg::FLG_COMMENT) != 0)
            return ghv_pkg::PH_COMMENT;
        if (cur < ghv_pkg::PH_CRC && (gz_flags & ghv_pkg::FLG_CRC) != 0)
            return ghv_pkg::PH_CRC;
        return ghv_pkg::PH_NONE;
    endfunction

    // advances the parser by one byte; returns 1 when a verdict is produced
    function automatic bit parse_header_byte(input logic [7:0] b, input bit last,
                                             output ghv_pkg::t_out_item res);
        logic [15:0]     p;
        int              verdict;
        bit              field_done;
        ghv_pkg::t_phase nxt;
        p = gz_pos;
        verdict = -1;
        field_done = 1'b0;
        res = '0;
        if (gz_decided) begin
            if (last) gz_restart();
            return 1'b0;
        end
        if (gz_pos != ghv_pkg::POS_MAX) gz_pos = gz_pos + 16'd1;
        case (gz_phase)
            ghv_pkg::PH_FIXED: begin
                if ((p == ghv_pkg::POS_MAGIC0 && b != ghv_pkg::MAGIC0) ||
                    (p == ghv_pkg::POS_MAGIC1 && b != ghv_pkg::MAGIC1) ||
                    (p == ghv_pkg::POS_METHOD && b != ghv_pkg::METHOD_DEFLATE) ||
                    (p == ghv_pkg::POS_FLAGS && (b & ghv_pkg::RESERVED_MASK) != 0)) begin
                    verdict = 0;
                end else begin
                    if (p == ghv_pkg::POS_FLAGS) gz_flags = b[4:0];
                    if (p >= ghv_pkg::POS_LAST_FIXED) begin
                        if (!gz_full) verdict = 1;
                        else field_done = 1'b1;
                    end else if (last) begin
                        verdict = 0;
                    end
                end
            end
            ghv_pkg::PH_XLO: begin
                gz_count = {8'h00, b};
                if (last) verdict = 0;
                else gz_phase = ghv_pkg::PH_XHI;
            end
            ghv_pkg::PH_XHI: begin
                gz_count = {b, gz_count[7:0]};
                if (gz_count == 0) field_done = 1'b1;
                else if (last) verdict = 0;
                else gz_phase = ghv_pkg::PH_XSKIP;
            end
            ghv_pkg::PH_XSKIP: begin
                if (gz_count != 0) gz_count = gz_count - 16'd1;
                if (gz_count == 0) field_done = 1'b1;
                else if (last) verdict = 0;
            end
            ghv_pkg::PH_NAME, ghv_pkg::PH_COMMENT: begin
                if (b == 8'h00 || last) field_done = 1'b1;
            end
            ghv_pkg::PH_CRC: begin
                if (gz_count == 0) begin
                    if (last) verdict = 0;
                    else gz_count = 16'd1;
                end else begin
                    field_done = 1'b1;
                end
            end
            default: verdict = 0;
        endcase
        if (field_done) begin
            nxt = next_optional_field(gz_phase);
            if (nxt == ghv_pkg::PH_NONE) verdict = 1;
            else if (last) verdict = 0;
            else begin
                gz_phase = nxt;
                gz_count = '0;
            end
        end
        if (verdict < 0) return 1'b0;
        res.is_gzip = (verdict == 1);
        res.header_bytes = gz_pos;
        if (last) gz_restart();
        else gz_decided = 1'b1;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want_v, got_v);
        error_count++;
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last);
        int unsigned        gap;
        ghv_pkg::t_out_item res;
        gap = $urandom_range(0, in_wait_max);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{data_byte: b, last_byte: last};
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        if (parse_header_byte(b, last, res)) verdict_q.push_back(res);
    endtask

    task automatic send_buffer();
        foreach (stim_bytes[i]) send_byte(stim_bytes[i], i == stim_bytes.size() - 1);
    endtask

    // stop sending and let every pending verdict come out
    task automatic drain_verdicts();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_full_check(input bit v);
        drain_verdicts();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        gz_full = v;
    endtask

    task automatic put_fixed_header(input logic [7:0] flg);
        stim_bytes = {ghv_pkg::MAGIC0, ghv_pkg::MAGIC1, ghv_pkg::METHOD_DEFLATE, flg};
        repeat (6) stim_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_gzip_buffer();
        int unsigned n;
        int unsigned cut;
        logic [4:0]  flg;
        logic [7:0]  flg_byte;
        flg = 5'($urandom_range(0, 31));
        flg_byte = {3'b000, flg};
        if ($urandom_range(0, 9) == 0) flg_byte[7:5] = 3'($urandom_range(1, 7));
        put_fixed_header(flg_byte);
        if ((flg & ghv_pkg::FLG_EXTRA) != 0) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 4);
            stim_bytes.push_back(n[7:0]);
            stim_bytes.push_back(n[15:8]);
            repeat (n) stim_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if ((flg & ghv_pkg::FLG_NAME) != 0) begin
            repeat ($urandom_range(0, 4)) stim_bytes.push_back(8'($urandom_range(1, 255)));
            stim_bytes.push_back(8'h00);
        end
        if ((flg & ghv_pkg::FLG_COMMENT) != 0) begin
            repeat ($urandom_range(0, 4)) stim_bytes.push_back(8'($urandom_range(1, 255)));
            stim_bytes.push_back(8'h00);
        end
        if ((flg & ghv_pkg::FLG_CRC) != 0)
            repeat (2) stim_bytes.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2)) stim_bytes.push_back(8'($urandom_range(0, 255)));
        // truncated buffers hit the short-buffer and missing-terminator paths
        if ($urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, stim_bytes.size());
            while (stim_bytes.size() > cut) void'(stim_bytes.pop_back());
        end
        if ($urandom_range(0, 11) == 0)
            stim_bytes[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
    endtask

    task automatic build_noise_buffer();
        stim_bytes = {};
        if ($urandom_range(0, 2) == 0) stim_bytes.push_back(ghv_pkg::MAGIC0);
        repeat ($urandom_range(1, 12)) stim_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic test_quick_mode();
        set_full_check(1'b0);
        stim_bytes = {ghv_pkg::MAGIC0, ghv_pkg::MAGIC1, ghv_pkg::METHOD_DEFLATE, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_buffer();
        put_fixed_header(8'h1F);
        stim_bytes.push_back(8'hAA);
        stim_bytes.push_back(8'h55);
        send_buffer();
        stim_bytes = {8'h1E, ghv_pkg::MAGIC1};
        send_buffer();
        stim_bytes = {ghv_pkg::MAGIC0, 8'h8A, 8'h00};
        send_buffer();
        stim_bytes = {ghv_pkg::MAGIC0, ghv_pkg::MAGIC1, 8'h07};
        send_buffer();
        put_fixed_header(8'h20);
        send_buffer();
        put_fixed_header(8'h80);
        send_buffer();
        // ends inside the fixed header
        stim_bytes = {ghv_pkg::MAGIC0, ghv_pkg::MAGIC1, ghv_pkg::METHOD_DEFLATE, 8'h00,
                      8'h00};
        send_buffer();
        stim_bytes = {ghv_pkg::MAGIC0};
        send_buffer();
        stim_bytes = {8'h00};
        send_buffer();
    endtask

    task automatic test_optional_fields();
        set_full_check(1'b1);
        put_fixed_header(8'h1E);
        stim_bytes = {stim_bytes, 8'h03, 8'h00, 8'h01, 8'h02, 8'h03, 8'h61, 8'h62, 8'h00,
                      8'h63, 8'h00, 8'h12, 8'h34, 8'hEE};
        send_buffer();
        put_fixed_header(8'h01);
        send_buffer();
        // zero-length extra field ends at its high length byte
        put_fixed_header(8'(ghv_pkg::FLG_EXTRA));
        stim_bytes = {stim_bytes, 8'h00, 8'h00, 8'h77};
        send_buffer();
        put_fixed_header(8'(ghv_pkg::FLG_NAME));
        stim_bytes = {stim_bytes, 8'h78, 8'h79};
        send_buffer();
        put_fixed_header(8'(ghv_pkg::FLG_NAME | ghv_pkg::FLG_COMMENT));
        stim_bytes.push_back(8'h78);
        send_buffer();
        put_fixed_header(8'(ghv_pkg::FLG_CRC));
        stim_bytes.push_back(8'h12);
        send_buffer();
        put_fixed_header(8'(ghv_pkg::FLG_EXTRA));
        stim_bytes = {stim_bytes, 8'h05, 8'h00, 8'h01, 8'h02};
        send_buffer();
        put_fixed_header(8'(ghv_pkg::FLG_EXTRA));
        stim_bytes.push_back(8'h05);
        send_buffer();
        stim_bytes = {ghv_pkg::MAGIC0, ghv_pkg::MAGIC1, ghv_pkg::METHOD_DEFLATE, 8'h00,
                      8'h00, 8'h00};
        send_buffer();
    endtask

    task automatic test_random_buffers(input bit full, input int unsigned byte_target);
        int unsigned start_count;
        set_full_check(full);
        start_count = bytes_sent;
        while (bytes_sent - start_count < byte_target) begin
            if ($urandom_range(0, 9) < 7) build_gzip_buffer();
            else build_noise_buffer();
            send_buffer();
        end
    endtask

    initial begin
        gz_full = 1'b0;
        gz_restart();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_quick_mode();
        test_optional_fields();
        test_random_buffers(1'b1, 100);
        test_random_buffers(1'b0, 60);
        in_wait_max  = 0;
        out_wait_max = 0;
        test_random_buffers(1'b1, 70);
        in_wait_max  = 14;
        out_wait_max = 3;
        test_random_buffers(1'b0, 40);
        out_wait_max = 14;
        test_random_buffers(1'b1, 60);

        drain_verdicts();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // receiver: a fresh stall length is drawn after every verdict taken
    always @(negedge i_clk) begin
        if (verdicts_drawn != verdicts_taken) begin
            verdicts_drawn = verdicts_taken;
            stall_left = $urandom_range(0, out_wait_max);
        end
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            verdicts_taken = verdicts_taken + 1;
            if (verdict_q.size() == 0) begin
                report_mismatch("verdict with none pending, is_gzip", 0, o_out_data.is_gzip);
            end else begin
                want = verdict_q.pop_front();
                if (o_out_data.is_gzip !== want.is_gzip)
                    report_mismatch("is_gzip", want.is_gzip, o_out_data.is_gzip);
                if (o_out_data.header_bytes !== want.header_bytes)
                    report_mismatch("header_bytes", want.header_bytes, o_out_data.header_bytes);
            end
        end
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

>>> gzip_header_validator.f
rtl/ghv_pkg.sv
rtl/ghv_front.sv
rtl/ghv_queue.sv
rtl/gzip_header_validator.sv
rtl/ghv_checker.sv
test/gzip_header_validator_tb.sv
